>>> sv/pfc_pkg.sv
`timescale 1ns / 1ps
// Shared types, table sizes and protocol constants for the packet forward classifier.
// Depends on nothing; every other file refers to it by scoped names.
package pfc_pkg;

    // Table sizes.
    localparam int ROUTE_ENTRIES = 64;
    localparam int PORT_ENTRIES  = 512;
    localparam int QUEUE_ENTRIES = 64;

    // Index widths, kept at one bit or more.
    localparam int ROUTE_AW = (ROUTE_ENTRIES > 1) ? $clog2(ROUTE_ENTRIES) : 1;
    localparam int PORT_AW  = (PORT_ENTRIES > 1) ? $clog2(PORT_ENTRIES) : 1;
    localparam int QUEUE_AW = (QUEUE_ENTRIES > 1) ? $clog2(QUEUE_ENTRIES) : 1;

    // Length of the clearing pass after reset and the width of its counter.
    localparam int CLR_LEN = (PORT_ENTRIES > QUEUE_ENTRIES) ? PORT_ENTRIES : QUEUE_ENTRIES;
    localparam int CLR_W   = $clog2(CLR_LEN + 1);

    // Stored word widths.
    localparam int ROUTE_INFO_W = 80;   // out interface (32) over MAC (48)
    localparam int PORT_WORD_W  = 33;   // valid bit over port value (32)
    localparam int QCONF_W      = 2;    // socket bound over enable

    // Protocol constants.
    localparam logic [15:0] ETHTYPE_IPV4 = 16'h0800;
    localparam logic [15:0] ETHTYPE_IPV6 = 16'h86DD;
    localparam logic [7:0]  PROTO_ICMP   = 8'd1;
    localparam logic [15:0] ETH_MIN_LEN  = 16'd14;
    localparam logic [15:0] IPV4_MIN_LEN = 16'd34;
    localparam logic [15:0] IPV6_MIN_LEN = 16'd54;

    typedef enum logic [1:0] {
        OP_PACKET   = 2'd0,
        OP_ROUTE_WR = 2'd1,
        OP_PORT_WR  = 2'd2,
        OP_QUEUE_WR = 2'd3
    } opcode_t;

    typedef enum logic [2:0] {
        ACT_PASS     = 3'd0,
        ACT_PORT     = 3'd1,
        ACT_SOCKET   = 3'd2,
        ACT_DROP     = 3'd3,
        ACT_WRITE_OK = 3'd4,
        ACT_FULL     = 3'd5
    } action_t;

    // Update request from the pipeline into the route CAM.
    typedef struct packed {
        logic                set;
        logic                clr;
        logic [ROUTE_AW-1:0] idx;
        logic [31:0]         key;
    } cam_upd_t;

    // Lookup result of the route CAM.
    typedef struct packed {
        logic                hit;
        logic [ROUTE_AW-1:0] hit_idx;
        logic                free_avail;
        logic [ROUTE_AW-1:0] free_idx;
    } cam_res_t;

    // Write controls of the clearing pass.
    typedef struct packed {
        logic                busy;
        logic                port_we;
        logic [PORT_AW-1:0]  port_addr;
        logic                queue_we;
        logic [QUEUE_AW-1:0] queue_addr;
    } clear_ctl_t;

endpackage

>>> sv/pfc_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data (old data on collision).
// Stands alone; used for the route, queue, port and port valid memories of the classifier.
module pfc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write and registered read; a read at the written address returns the old word.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> sv/pfc_route_cam.sv
`timescale 1ns / 1ps
// Route key CAM: valid bits and keys in flip-flops, parallel match, lowest free slot.
// Depends on pfc_pkg.
module pfc_route_cam (
    input  logic              clk,
    input  logic              rst_n,
    input  logic [31:0]       lookup_key,
    input  pfc_pkg::cam_upd_t upd,
    output pfc_pkg::cam_res_t res
);

    logic [pfc_pkg::ROUTE_ENTRIES-1:0] vld_reg;
    logic [31:0]                       key_reg [pfc_pkg::ROUTE_ENTRIES];
    logic [pfc_pkg::ROUTE_ENTRIES-1:0] match;

    // Compare every stored key against the lookup key.
    always_comb
    begin
        for (int i = 0; i < pfc_pkg::ROUTE_ENTRIES; i++)
        begin
            match[i] = vld_reg[i] && (key_reg[i] == lookup_key);
        end
    end

    // Lowest matching entry and lowest free entry.
    always_comb
    begin
        res = '0;
        for (int i = pfc_pkg::ROUTE_ENTRIES - 1; i >= 0; i--)
        begin
            if (match[i])
            begin
                res.hit     = 1'b1;
                res.hit_idx = pfc_pkg::ROUTE_AW'(i);
            end
            if (!vld_reg[i])
            begin
                res.free_avail = 1'b1;
                res.free_idx   = pfc_pkg::ROUTE_AW'(i);
            end
        end
    end

    // Valid bits clear at reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (upd.set)
        begin
            vld_reg[upd.idx] <= 1'b1;
        end
        else if (upd.clr)
        begin
            vld_reg[upd.idx] <= 1'b0;
        end
    end

    // Key storage is only read behind its valid bit.
    always_ff @(posedge clk)
    begin
        if (upd.set)
        begin
            key_reg[upd.idx] <= upd.key;
        end
    end

endmodule

>>> sv/pfc_clear.sv
`timescale 1ns / 1ps
// Clearing pass after reset: sweeps the port and queue tables one entry per cycle.
// Depends on pfc_pkg.
module pfc_clear (
    input  logic                clk,
    input  logic                rst_n,
    output pfc_pkg::clear_ctl_t ctl
);

    logic [pfc_pkg::CLR_W-1:0] cnt_reg;
    logic [pfc_pkg::CLR_W-1:0] cnt_next;
    logic                      busy;

    // The pass runs until the counter reaches the larger table depth.
    always_comb
    begin
        busy           = cnt_reg < pfc_pkg::CLR_W'(pfc_pkg::CLR_LEN);
        cnt_next       = busy ? cnt_reg + pfc_pkg::CLR_W'(1) : cnt_reg;
        ctl.busy       = busy;
        ctl.port_we    = cnt_reg < pfc_pkg::CLR_W'(pfc_pkg::PORT_ENTRIES);
        ctl.port_addr  = cnt_reg[pfc_pkg::PORT_AW-1:0];
        ctl.queue_we   = cnt_reg < pfc_pkg::CLR_W'(pfc_pkg::QUEUE_ENTRIES);
        ctl.queue_addr = cnt_reg[pfc_pkg::QUEUE_AW-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

endmodule

>>> sv/packet_forward_classifier_top.sv
`timescale 1ns / 1ps
// Top level of the packet forward classifier: four-stage lookup pipeline and result register.
// Depends on pfc_pkg, pfc_ram, pfc_route_cam and pfc_clear.
//
//  Channel   Handshake              Payload
//  --------  ---------------------  -----------------------------------------------
//  packet    pkt_valid / pkt_stall  opcode .. socket_bound (header or table write)
//  result    res_valid / res_stall  action, out_port, socket_queue, mac_rewritten,
//                                   new_mac
//  config    cfg_valid / cfg_ready  target_protocol (always ready)
//
// One item is taken per cycle while pkt_stall is low. Its result passes the stage registers
// and the chain of registered table reads (route CAM and route/queue memory, port entry at
// the out interface, then the port valid bit) into the result register.
// After reset pkt_stall stays high while the port and queue tables are cleared. A stalled
// result freezes the whole pipeline and raises pkt_stall in the same cycle.
module packet_forward_classifier_top (
    input  logic        clk,
    input  logic        rst_n,
    // Packet channel.
    input  logic        pkt_valid,
    output logic        pkt_stall,
    input  logic [1:0]  opcode,
    input  logic [15:0] frame_length,
    input  logic [15:0] ethertype,
    input  logic [31:0] ip_destination,
    input  logic [7:0]  protocol,
    input  logic [7:0]  rx_queue,
    input  logic        entry_valid,
    input  logic [31:0] table_value,
    input  logic [8:0]  table_key,
    input  logic [47:0] dest_mac,
    input  logic        socket_bound,
    // Result channel.
    output logic        res_valid,
    input  logic        res_stall,
    output logic [2:0]  action,
    output logic [8:0]  out_port,
    output logic [5:0]  socket_queue,
    output logic        mac_rewritten,
    output logic [47:0] new_mac,
    // Configuration channel.
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  target_protocol
);

    typedef struct packed {
        logic [1:0]  opcode;
        logic [15:0] frame_length;
        logic [15:0] ethertype;
        logic [31:0] ip_destination;
        logic [7:0]  protocol;
        logic [7:0]  rx_queue;
        logic        entry_valid;
        logic [31:0] table_value;
        logic [8:0]  table_key;
        logic [47:0] dest_mac;
        logic        socket_bound;
    } item_t;

    typedef struct packed {
        logic                        is_packet;
        logic                        early_pass;
        logic                        is_v4;
        logic                        proto_hit;
        logic                        route_hit;
        logic [5:0]                  q;
        pfc_pkg::action_t            wr_action;
        logic                        port_we;
        logic [pfc_pkg::PORT_AW-1:0] port_key;
        logic                        port_vld;
        logic [31:0]                 port_val;
    } s2_t;

    typedef struct packed {
        logic                        is_packet;
        logic                        early_pass;
        logic                        is_v4;
        logic                        proto_hit;
        logic                        route_hit;
        logic                        ifc_ok;
        logic [5:0]                  q;
        pfc_pkg::action_t            wr_action;
        logic [47:0]                 mac;
        logic [pfc_pkg::QCONF_W-1:0] qconf;
    } s3_t;

    typedef struct packed {
        logic                        is_packet;
        logic                        early_pass;
        logic                        is_v4;
        logic                        proto_hit;
        logic                        fwd;
        logic                        p_ok;
        logic [8:0]                  p_lo;
        logic [5:0]                  q;
        pfc_pkg::action_t            wr_action;
        logic [47:0]                 mac;
        logic [pfc_pkg::QCONF_W-1:0] qconf;
    } s4_t;

    // Pipeline control and stage registers.
    logic adv;
    logic pkt_accept;
    logic s1_vld_reg, s2_vld_reg, s3_vld_reg, s4_vld_reg;
    item_t s1_item_reg;
    s2_t   s2_reg, s2_next;
    s3_t   s3_reg, s3_next;
    s4_t   s4_reg, s4_next;

    // Result register.
    logic             res_valid_reg;
    pfc_pkg::action_t res_action_reg, res_action_next;
    logic [8:0]       res_port_reg, res_port_next;
    logic [5:0]       res_queue_reg, res_queue_next;
    logic             res_mac_rw_reg, res_mac_rw_next;
    logic [47:0]      res_mac_reg, res_mac_next;

    logic [7:0] target_protocol_reg;

    // Submodule connections.
    pfc_pkg::clear_ctl_t clr;
    pfc_pkg::cam_upd_t   cam_upd;
    pfc_pkg::cam_res_t   cam_res;

    logic [pfc_pkg::ROUTE_INFO_W-1:0] route_rd;
    logic [pfc_pkg::QCONF_W-1:0]      queue_rd;
    logic                             queue_we;
    logic [pfc_pkg::QUEUE_AW-1:0]     queue_waddr;
    logic [pfc_pkg::QCONF_W-1:0]      queue_wdata;

    logic [pfc_pkg::PORT_WORD_W-1:0]  port_rd;
    logic                             port_we;
    logic [pfc_pkg::PORT_AW-1:0]      port_waddr;
    logic [pfc_pkg::PORT_WORD_W-1:0]  port_wdata;
    logic                             pvld_rd;
    logic [31:0]                      ifc;
    logic [31:0]                      pval;

    // Stage 1 decode.
    pfc_pkg::opcode_t s1_op;
    logic             q_ok;
    logic             key_ok;
    logic             is_v4;
    logic             is_v6;
    pfc_pkg::action_t s1_wr_action;

    // Handshake: the pipeline moves whenever the result register can take a word.
    assign adv        = !res_valid_reg || !res_stall;
    assign pkt_stall  = clr.busy || !adv;
    assign pkt_accept = pkt_valid && !pkt_stall;
    assign cfg_ready  = 1'b1;

    pfc_clear u_clear (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (clr)
    );

    // Stage 1: route CAM match, route write, queue table read and write.
    always_comb
    begin
        s1_op  = pfc_pkg::opcode_t'(s1_item_reg.opcode);
        q_ok   = 32'(s1_item_reg.rx_queue) < 32'(pfc_pkg::QUEUE_ENTRIES);
        key_ok = 32'(s1_item_reg.table_key) < 32'(pfc_pkg::PORT_ENTRIES);
        is_v4  = s1_item_reg.ethertype == pfc_pkg::ETHTYPE_IPV4;
        is_v6  = s1_item_reg.ethertype == pfc_pkg::ETHTYPE_IPV6;

        cam_upd.set = adv && s1_vld_reg && (s1_op == pfc_pkg::OP_ROUTE_WR)
                      && s1_item_reg.entry_valid && (cam_res.hit || cam_res.free_avail);
        cam_upd.clr = adv && s1_vld_reg && (s1_op == pfc_pkg::OP_ROUTE_WR)
                      && !s1_item_reg.entry_valid && cam_res.hit;
        cam_upd.idx = cam_res.hit ? cam_res.hit_idx : cam_res.free_idx;
        cam_upd.key = s1_item_reg.ip_destination;

        unique case (s1_op)
            pfc_pkg::OP_PACKET:
            begin
                s1_wr_action = pfc_pkg::ACT_PASS;
            end
            pfc_pkg::OP_ROUTE_WR:
            begin
                if (!s1_item_reg.entry_valid || cam_res.hit || cam_res.free_avail)
                begin
                    s1_wr_action = pfc_pkg::ACT_WRITE_OK;
                end
                else
                begin
                    s1_wr_action = pfc_pkg::ACT_FULL;
                end
            end
            pfc_pkg::OP_PORT_WR:
            begin
                s1_wr_action = key_ok ? pfc_pkg::ACT_WRITE_OK : pfc_pkg::ACT_FULL;
            end
            pfc_pkg::OP_QUEUE_WR:
            begin
                s1_wr_action = q_ok ? pfc_pkg::ACT_WRITE_OK : pfc_pkg::ACT_FULL;
            end
            default:
            begin
                s1_wr_action = pfc_pkg::ACT_PASS;
            end
        endcase

        // Queue table: the clearing pass owns the write port while it runs.
        if (clr.busy)
        begin
            queue_we    = clr.queue_we;
            queue_waddr = clr.queue_addr;
            queue_wdata = '0;
        end
        else
        begin
            queue_we    = adv && s1_vld_reg && (s1_op == pfc_pkg::OP_QUEUE_WR) && q_ok;
            queue_waddr = pfc_pkg::QUEUE_AW'(s1_item_reg.rx_queue);
            queue_wdata = s1_item_reg.entry_valid
                          ? {s1_item_reg.socket_bound, s1_item_reg.table_value != 32'd0}
                          : '0;
        end

        s2_next.is_packet  = s1_op == pfc_pkg::OP_PACKET;
        s2_next.early_pass = !q_ok || (s1_item_reg.frame_length < pfc_pkg::ETH_MIN_LEN)
                             || (is_v4 && (s1_item_reg.frame_length < pfc_pkg::IPV4_MIN_LEN))
                             || (is_v6 && (s1_item_reg.frame_length < pfc_pkg::IPV6_MIN_LEN));
        s2_next.is_v4      = is_v4;
        s2_next.proto_hit  = (is_v4 || is_v6)
                             && (s1_item_reg.protocol == target_protocol_reg);
        s2_next.route_hit  = cam_res.hit;
        s2_next.q          = s1_item_reg.rx_queue[5:0];
        s2_next.wr_action  = s1_wr_action;
        s2_next.port_we    = (s1_op == pfc_pkg::OP_PORT_WR) && key_ok;
        s2_next.port_key   = pfc_pkg::PORT_AW'(s1_item_reg.table_key);
        s2_next.port_vld   = s1_item_reg.entry_valid;
        s2_next.port_val   = s1_item_reg.table_value;
    end

    pfc_route_cam u_route_cam (
        .clk        (clk),
        .rst_n      (rst_n),
        .lookup_key (s1_item_reg.ip_destination),
        .upd        (cam_upd),
        .res        (cam_res)
    );

    pfc_ram #(
        .WIDTH (pfc_pkg::ROUTE_INFO_W),
        .DEPTH (pfc_pkg::ROUTE_ENTRIES)
    ) u_route_ram (
        .clk   (clk),
        .we    (cam_upd.set),
        .waddr (cam_upd.idx),
        .wdata ({s1_item_reg.table_value, s1_item_reg.dest_mac}),
        .re    (adv),
        .raddr (cam_res.hit_idx),
        .rdata (route_rd)
    );

    pfc_ram #(
        .WIDTH (pfc_pkg::QCONF_W),
        .DEPTH (pfc_pkg::QUEUE_ENTRIES)
    ) u_queue_ram (
        .clk   (clk),
        .we    (queue_we),
        .waddr (queue_waddr),
        .wdata (queue_wdata),
        .re    (adv),
        .raddr (pfc_pkg::QUEUE_AW'(s1_item_reg.rx_queue)),
        .rdata (queue_rd)
    );

    // Stage 2: port entry read at the route's out interface, port table writes.
    always_comb
    begin
        ifc = route_rd[pfc_pkg::ROUTE_INFO_W-1:48];

        if (clr.busy)
        begin
            port_we    = clr.port_we;
            port_waddr = clr.port_addr;
            port_wdata = '0;
        end
        else
        begin
            port_we    = adv && s2_vld_reg && s2_reg.port_we;
            port_waddr = s2_reg.port_key;
            port_wdata = {s2_reg.port_vld, s2_reg.port_vld ? s2_reg.port_val : 32'd0};
        end

        s3_next.is_packet  = s2_reg.is_packet;
        s3_next.early_pass = s2_reg.early_pass;
        s3_next.is_v4      = s2_reg.is_v4;
        s3_next.proto_hit  = s2_reg.proto_hit;
        s3_next.route_hit  = s2_reg.route_hit;
        s3_next.ifc_ok     = ifc < 32'(pfc_pkg::PORT_ENTRIES);
        s3_next.q          = s2_reg.q;
        s3_next.wr_action  = s2_reg.wr_action;
        s3_next.mac        = route_rd[47:0];
        s3_next.qconf      = queue_rd;
    end

    pfc_ram #(
        .WIDTH (pfc_pkg::PORT_WORD_W),
        .DEPTH (pfc_pkg::PORT_ENTRIES)
    ) u_port_ram (
        .clk   (clk),
        .we    (port_we),
        .waddr (port_waddr),
        .wdata (port_wdata),
        .re    (adv),
        .raddr (ifc[pfc_pkg::PORT_AW-1:0]),
        .rdata (port_rd)
    );

    // Stage 3: valid bit of the mapped port, from a copy of the port valid bits.
    always_comb
    begin
        pval = port_rd[31:0];

        s4_next.is_packet  = s3_reg.is_packet;
        s4_next.early_pass = s3_reg.early_pass;
        s4_next.is_v4      = s3_reg.is_v4;
        s4_next.proto_hit  = s3_reg.proto_hit;
        s4_next.fwd        = s3_reg.route_hit && s3_reg.ifc_ok
                             && port_rd[pfc_pkg::PORT_WORD_W-1];
        s4_next.p_ok       = pval < 32'(pfc_pkg::PORT_ENTRIES);
        s4_next.p_lo       = pval[8:0];
        s4_next.q          = s3_reg.q;
        s4_next.wr_action  = s3_reg.wr_action;
        s4_next.mac        = s3_reg.mac;
        s4_next.qconf      = s3_reg.qconf;
    end

    pfc_ram #(
        .WIDTH (1),
        .DEPTH (pfc_pkg::PORT_ENTRIES)
    ) u_port_vld_ram (
        .clk   (clk),
        .we    (port_we),
        .waddr (port_waddr),
        .wdata (port_wdata[pfc_pkg::PORT_WORD_W-1]),
        .re    (adv),
        .raddr (pval[pfc_pkg::PORT_AW-1:0]),
        .rdata (pvld_rd)
    );

    // Stage 4: final decision into the result register.
    always_comb
    begin
        res_action_next = pfc_pkg::ACT_PASS;
        res_port_next   = '0;
        res_queue_next  = '0;
        res_mac_rw_next = 1'b0;
        res_mac_next    = '0;

        priority if (!s4_reg.is_packet)
        begin
            res_action_next = s4_reg.wr_action;
        end
        else if (s4_reg.early_pass)
        begin
            res_action_next = pfc_pkg::ACT_PASS;
        end
        else if (s4_reg.is_v4 && s4_reg.fwd)
        begin
            if (s4_reg.p_ok && pvld_rd)
            begin
                res_action_next = pfc_pkg::ACT_PORT;
                res_port_next   = s4_reg.p_lo;
                res_mac_rw_next = 1'b1;
                res_mac_next    = s4_reg.mac;
            end
            else
            begin
                res_action_next = pfc_pkg::ACT_DROP;
            end
        end
        else if (s4_reg.proto_hit && s4_reg.qconf[0])
        begin
            if (s4_reg.qconf[1])
            begin
                res_action_next = pfc_pkg::ACT_SOCKET;
                res_queue_next  = s4_reg.q;
            end
            else
            begin
                res_action_next = pfc_pkg::ACT_DROP;
            end
        end
        else
        begin
            res_action_next = pfc_pkg::ACT_PASS;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg          <= 1'b0;
            s2_vld_reg          <= 1'b0;
            s3_vld_reg          <= 1'b0;
            s4_vld_reg          <= 1'b0;
            res_valid_reg       <= 1'b0;
            target_protocol_reg <= pfc_pkg::PROTO_ICMP;
        end
        else
        begin
            if (adv)
            begin
                s1_vld_reg    <= pkt_accept;
                s2_vld_reg    <= s1_vld_reg;
                s3_vld_reg    <= s2_vld_reg;
                s4_vld_reg    <= s3_vld_reg;
                res_valid_reg <= s4_vld_reg;
            end
            if (cfg_valid && cfg_ready)
            begin
                target_protocol_reg <= target_protocol;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (pkt_accept)
        begin
            s1_item_reg <= '{opcode: opcode, frame_length: frame_length,
                             ethertype: ethertype, ip_destination: ip_destination,
                             protocol: protocol, rx_queue: rx_queue,
                             entry_valid: entry_valid, table_value: table_value,
                             table_key: table_key, dest_mac: dest_mac,
                             socket_bound: socket_bound};
        end
        if (adv)
        begin
            s2_reg         <= s2_next;
            s3_reg         <= s3_next;
            s4_reg         <= s4_next;
            res_action_reg <= res_action_next;
            res_port_reg   <= res_port_next;
            res_queue_reg  <= res_queue_next;
            res_mac_rw_reg <= res_mac_rw_next;
            res_mac_reg    <= res_mac_next;
        end
    end

    assign res_valid     = res_valid_reg;
    assign action        = res_action_reg;
    assign out_port      = res_port_reg;
    assign socket_queue  = res_queue_reg;
    assign mac_rewritten = res_mac_rw_reg;
    assign new_mac       = res_mac_reg;

endmodule

>>> sv/pfc_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the packet forward classifier, bound to the top level.
// Depends on pfc_pkg and packet_forward_classifier_top.
module pfc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        pkt_stall,
    input logic        res_valid,
    input logic        res_stall,
    input logic [2:0]  action,
    input logic [8:0]  out_port,
    input logic [5:0]  socket_queue,
    input logic        mac_rewritten,
    input logic [47:0] new_mac
);

    // A stalled result stays offered.
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid)
        else $error("result dropped while stalled");

    // A stalled result keeps its payload.
    a_res_stable: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> $stable(action) && $stable(out_port)
            && $stable(socket_queue) && $stable(mac_rewritten) && $stable(new_mac))
        else $error("result payload changed while stalled");

    // Port and MAC fields are only set on a port redirect.
    a_port_fields: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (action != pfc_pkg::ACT_PORT)
            |-> !mac_rewritten && (out_port == 9'd0) && (new_mac == 48'd0))
        else $error("port fields set without a port redirect");

    // The socket queue is only set on a socket redirect.
    a_socket_field: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (action != pfc_pkg::ACT_SOCKET) |-> (socket_queue == 6'd0))
        else $error("socket queue set without a socket redirect");

    // The table clearing pass holds off packets right after reset.
    a_clear_stall: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> pkt_stall)
        else $error("packet accepted before table clearing");

endmodule

bind packet_forward_classifier_top pfc_checker u_pfc_checker (.*);

>>> tb/tb_packet_forward_classifier_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for packet_forward_classifier_top: directed and random headers and
// table writes, checked against an in-bench forwarding model. Depends on pfc_pkg and the RTL.
module tb_packet_forward_classifier_top;

    localparam int PIPE_LATENCY = 4;
    localparam int QUIET_LIMIT  = 3000;
    localparam int RANDOM_BATCH = 150;

    // One request on the packet channel: a header or a table write.
    typedef struct packed {
        pfc_pkg::opcode_t op;
        logic [15:0]      frame_length;
        logic [15:0]      ethertype;
        logic [31:0]      ip_destination;
        logic [7:0]       protocol;
        logic [7:0]       rx_queue;
        logic             entry_valid;
        logic [31:0]      table_value;
        logic [8:0]       table_key;
        logic [47:0]      dest_mac;
        logic             socket_bound;
    } request_t;

    // One forwarding decision on the result channel.
    typedef struct packed {
        pfc_pkg::action_t action;
        logic [8:0]       out_port;
        logic [5:0]       socket_queue;
        logic             mac_rewritten;
        logic [47:0]      new_mac;
    } decision_t;

    logic        clk;
    logic        rst_n = 1'b0;
    logic        pkt_valid = 1'b0;
    logic        pkt_stall;
    logic [1:0]  opcode = '0;
    logic [15:0] frame_length = '0;
    logic [15:0] ethertype = '0;
    logic [31:0] ip_destination = '0;
    logic [7:0]  protocol = '0;
    logic [7:0]  rx_queue = '0;
    logic        entry_valid = 1'b0;
    logic [31:0] table_value = '0;
    logic [8:0]  table_key = '0;
    logic [47:0] dest_mac = '0;
    logic        socket_bound = 1'b0;
    logic        res_valid;
    logic        res_stall = 1'b0;
    logic [2:0]  action;
    logic [8:0]  out_port;
    logic [5:0]  socket_queue;
    logic        mac_rewritten;
    logic [47:0] new_mac;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [7:0]  target_protocol = '0;

    // Forwarding model state.
    logic        route_ok  [pfc_pkg::ROUTE_ENTRIES];
    logic [31:0] route_key [pfc_pkg::ROUTE_ENTRIES];
    logic [31:0] route_ifc [pfc_pkg::ROUTE_ENTRIES];
    logic [47:0] route_mac [pfc_pkg::ROUTE_ENTRIES];
    logic        port_ok   [pfc_pkg::PORT_ENTRIES];
    logic [31:0] port_val  [pfc_pkg::PORT_ENTRIES];
    logic [1:0]  queue_cfg [pfc_pkg::QUEUE_ENTRIES];
    logic [7:0]  steer_protocol;

    // Value pools that make routes, port entries and queues meet each other.
    logic [31:0] addr_pool  [8];
    logic [8:0]  slot_pool  [16];
    logic [7:0]  queue_pool [8];
    logic [31:0] flood_keys [pfc_pkg::ROUTE_ENTRIES + 6];

    request_t  request_queue [$];
    decision_t decisions_due [$];
    request_t  on_wire;
    int        requests_queued = 0;
    int        requests_accepted = 0;
    int        mismatch_count = 0;
    int        protocol_settings = 1;
    int        action_tally [8];
    int        send_gap = 0;
    int        stall_left = 0;
    int        quiet_cycles = 0;
    bit        idle_enabled = 1'b1;

    packet_forward_classifier_top dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .pkt_valid      (pkt_valid),
        .pkt_stall      (pkt_stall),
        .opcode         (opcode),
        .frame_length   (frame_length),
        .ethertype      (ethertype),
        .ip_destination (ip_destination),
        .protocol       (protocol),
        .rx_queue       (rx_queue),
        .entry_valid    (entry_valid),
        .table_value    (table_value),
        .table_key      (table_key),
        .dest_mac       (dest_mac),
        .socket_bound   (socket_bound),
        .res_valid      (res_valid),
        .res_stall      (res_stall),
        .action         (action),
        .out_port       (out_port),
        .socket_queue   (socket_queue),
        .mac_rewritten  (mac_rewritten),
        .new_mac        (new_mac),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .target_protocol(target_protocol)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Slot of the valid route entry holding this key, or -1.
    function automatic int route_slot_of(input logic [31:0] key);
        int slot;
        slot = -1;
        for (int i = 0; i < pfc_pkg::ROUTE_ENTRIES; i++)
        begin
            if (slot < 0 && route_ok[i] && route_key[i] == key)
                slot = i;
        end
        return slot;
    endfunction

    // Applies one request to the model tables and returns the decision it must produce.
    function automatic decision_t forward_decision(input request_t r);
        decision_t   d;
        int          slot;
        logic [31:0] ifc;
        logic [31:0] port;
        logic [1:0]  qc;
        logic        proto_hit;
        logic        settled;
        d = '0;
        d.action = pfc_pkg::ACT_PASS;
        proto_hit = 1'b0;
        settled = 1'b0;
        case (r.op)
            pfc_pkg::OP_PACKET:
            begin
                if (r.rx_queue < pfc_pkg::QUEUE_ENTRIES
                    && r.frame_length >= pfc_pkg::ETH_MIN_LEN)
                begin
                    qc = queue_cfg[r.rx_queue[pfc_pkg::QUEUE_AW-1:0]];
                    if (r.ethertype == pfc_pkg::ETHTYPE_IPV4)
                    begin
                        if (r.frame_length < pfc_pkg::IPV4_MIN_LEN)
                            settled = 1'b1;
                        else
                        begin
                            // A route hit with a valid out interface settles the packet.
                            slot = route_slot_of(r.ip_destination);
                            if (slot >= 0)
                            begin
                                ifc = route_ifc[slot];
                                if (ifc < pfc_pkg::PORT_ENTRIES
                                    && port_ok[ifc[pfc_pkg::PORT_AW-1:0]])
                                begin
                                    port = port_val[ifc[pfc_pkg::PORT_AW-1:0]];
                                    if (port < pfc_pkg::PORT_ENTRIES
                                        && port_ok[port[pfc_pkg::PORT_AW-1:0]])
                                    begin
                                        d.action = pfc_pkg::ACT_PORT;
                                        d.out_port = port[pfc_pkg::PORT_AW-1:0];
                                        d.mac_rewritten = 1'b1;
                                        d.new_mac = route_mac[slot];
                                    end
                                    else
                                        d.action = pfc_pkg::ACT_DROP;
                                    settled = 1'b1;
                                end
                            end
                            proto_hit = !settled && r.protocol == steer_protocol;
                        end
                    end
                    else if (r.ethertype == pfc_pkg::ETHTYPE_IPV6)
                    begin
                        if (r.frame_length < pfc_pkg::IPV6_MIN_LEN)
                            settled = 1'b1;
                        else
                            proto_hit = r.protocol == steer_protocol;
                    end
                    // Steering needs an enabled queue; without a bound socket it drops.
                    if (!settled && proto_hit && qc[0])
                    begin
                        if (qc[1])
                        begin
                            d.action = pfc_pkg::ACT_SOCKET;
                            d.socket_queue = r.rx_queue[pfc_pkg::QUEUE_AW-1:0];
                        end
                        else
                            d.action = pfc_pkg::ACT_DROP;
                    end
                end
            end
            pfc_pkg::OP_ROUTE_WR:
            begin
                d.action = pfc_pkg::ACT_WRITE_OK;
                slot = route_slot_of(r.ip_destination);
                if (!r.entry_valid)
                begin
                    if (slot >= 0)
                        route_ok[slot] = 1'b0;
                end
                else
                begin
                    // A new key takes the lowest free slot.
                    for (int i = 0; i < pfc_pkg::ROUTE_ENTRIES; i++)
                    begin
                        if (slot < 0 && !route_ok[i])
                            slot = i;
                    end
                    if (slot < 0)
                        d.action = pfc_pkg::ACT_FULL;
                    else
                    begin
                        route_ok[slot] = 1'b1;
                        route_key[slot] = r.ip_destination;
                        route_ifc[slot] = r.table_value;
                        route_mac[slot] = r.dest_mac;
                    end
                end
            end
            pfc_pkg::OP_PORT_WR:
            begin
                if (r.table_key >= pfc_pkg::PORT_ENTRIES)
                    d.action = pfc_pkg::ACT_FULL;
                else
                begin
                    port_ok[r.table_key] = r.entry_valid;
                    port_val[r.table_key] = r.entry_valid ? r.table_value : 32'd0;
                    d.action = pfc_pkg::ACT_WRITE_OK;
                end
            end
            pfc_pkg::OP_QUEUE_WR:
            begin
                if (r.rx_queue >= pfc_pkg::QUEUE_ENTRIES)
                    d.action = pfc_pkg::ACT_FULL;
                else
                begin
                    queue_cfg[r.rx_queue[pfc_pkg::QUEUE_AW-1:0]] =
                        r.entry_valid ? {r.socket_bound, r.table_value != 32'd0} : 2'b00;
                    d.action = pfc_pkg::ACT_WRITE_OK;
                end
            end
        endcase
        return d;
    endfunction

    // Random content in every field; callers overwrite the fields that matter.
    function automatic request_t noise_request();
        request_t    r;
        logic [31:0] w;
        w = $urandom();
        r.frame_length = w[15:0];
        r.ethertype = w[31:16];
        r.ip_destination = $urandom();
        w = $urandom();
        r.protocol = w[7:0];
        r.rx_queue = w[15:8];
        r.entry_valid = w[16];
        r.socket_bound = w[17];
        r.table_key = w[26:18];
        r.table_value = $urandom();
        w = $urandom();
        r.dest_mac[47:32] = w[15:0];
        r.dest_mac[31:0] = $urandom();
        r.op = pfc_pkg::OP_PACKET;
        return r;
    endfunction

    function automatic logic [47:0] rand_mac();
        logic [31:0] w;
        w = $urandom();
        return {w[15:0], $urandom()};
    endfunction

    function automatic logic [31:0] pick_addr();
        logic [31:0] w;
        w = $urandom();
        if (w[31:29] == 3'd0)
            return $urandom();
        return addr_pool[w[2:0]];
    endfunction

    function automatic logic [8:0] pick_slot();
        logic [31:0] w;
        w = $urandom();
        if (w[31:29] == 3'd0)
            return w[8:0];
        return slot_pool[w[3:0]];
    endfunction

    // Out interface or port value: mostly a pooled slot, sometimes past the port table.
    function automatic logic [31:0] pick_ifc();
        logic [31:0] w;
        w = $urandom();
        if (w[31:28] == 4'd0)
            return w;
        if (w[31:28] == 4'd1)
            return 32'd512 + {23'd0, w[8:0]};
        return {23'd0, slot_pool[w[3:0]]};
    endfunction

    function automatic logic [7:0] pick_queue();
        logic [31:0] w;
        w = $urandom();
        if (w[31:28] == 4'd0)
            return w[7:0];
        return queue_pool[w[2:0]];
    endfunction

    task automatic add_packet(input logic [15:0] etype, input logic [15:0] len,
                              input logic [31:0] dest, input logic [7:0] proto,
                              input logic [7:0] queue);
        request_t r;
        r = noise_request();
        r.op = pfc_pkg::OP_PACKET;
        r.ethertype = etype;
        r.frame_length = len;
        r.ip_destination = dest;
        r.protocol = proto;
        r.rx_queue = queue;
        request_queue.push_back(r);
        requests_queued++;
    endtask

    task automatic add_route(input logic [31:0] key, input logic valid,
                             input logic [31:0] ifc, input logic [47:0] mac);
        request_t r;
        r = noise_request();
        r.op = pfc_pkg::OP_ROUTE_WR;
        r.ip_destination = key;
        r.entry_valid = valid;
        r.table_value = ifc;
        r.dest_mac = mac;
        request_queue.push_back(r);
        requests_queued++;
    endtask

    task automatic add_port(input logic [8:0] slot, input logic valid, input logic [31:0] value);
        request_t r;
        r = noise_request();
        r.op = pfc_pkg::OP_PORT_WR;
        r.table_key = slot;
        r.entry_valid = valid;
        r.table_value = value;
        request_queue.push_back(r);
        requests_queued++;
    endtask

    task automatic add_queue(input logic [7:0] queue, input logic valid,
                             input logic [31:0] value, input logic bound);
        request_t r;
        r = noise_request();
        r.op = pfc_pkg::OP_QUEUE_WR;
        r.rx_queue = queue;
        r.entry_valid = valid;
        r.table_value = value;
        r.socket_bound = bound;
        request_queue.push_back(r);
        requests_queued++;
    endtask

    // Mix of table writes and headers, weighted toward packets that reach the tables.
    task automatic add_random_request();
        logic [31:0] w;
        logic [31:0] v;
        logic [15:0] etype;
        logic [15:0] len;
        logic [15:0] edge_len [8];
        int          pick;
        edge_len = '{16'd13, 16'd14, 16'd33, 16'd34, 16'd53, 16'd54, 16'd0, 16'hFFFF};
        w = $urandom();
        v = $urandom();
        pick = $urandom_range(0, 99);
        if (pick < 14)
            add_route(pick_addr(), $urandom_range(0, 5) != 0, pick_ifc(), rand_mac());
        else if (pick < 28)
            add_port(pick_slot(), $urandom_range(0, 5) != 0, pick_ifc());
        else if (pick < 38)
            add_queue(pick_queue(), $urandom_range(0, 4) != 0,
                      (w[1:0] == 2'd0) ? 32'd0 : v, w[3:2] != 2'd0);
        else
        begin
            if (w[3:0] < 4'd10)
                etype = pfc_pkg::ETHTYPE_IPV4;
            else if (w[3:0] < 4'd14)
                etype = pfc_pkg::ETHTYPE_IPV6;
            else
                etype = w[31:16];
            if (w[7:4] == 4'd0)
                len = v[31:16];
            else if (w[7:4] == 4'd1)
                len = edge_len[w[10:8]];
            else
                len = 16'd54 + {7'd0, w[24:16]};
            add_packet(etype, len, pick_addr(), w[11] ? steer_protocol : v[7:0], pick_queue());
        end
    endtask

    task automatic wait_idle();
        while (request_queue.size() != 0 || requests_accepted != requests_queued
               || decisions_due.size() != 0)
            @(posedge clk);
    endtask

    // Register write once the pipeline has drained.
    task automatic write_steer_protocol(input logic [7:0] value);
        wait_idle();
        repeat (PIPE_LATENCY + 4) @(posedge clk);
        cfg_valid <= 1'b1;
        target_protocol <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        steer_protocol = value;
        cfg_valid <= 1'b0;
        protocol_settings++;
    endtask

    // Packet channel driver: presents queued requests and predicts each transfer.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pkt_valid <= 1'b0;
            send_gap = 0;
        end
        else
        begin
            if (pkt_valid && !pkt_stall)
            begin
                decisions_due.push_back(forward_decision(on_wire));
                requests_accepted++;
            end
            if (!pkt_valid || !pkt_stall)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    pkt_valid <= 1'b0;
                end
                else if (request_queue.size() != 0)
                begin
                    on_wire = request_queue.pop_front();
                    opcode <= on_wire.op;
                    frame_length <= on_wire.frame_length;
                    ethertype <= on_wire.ethertype;
                    ip_destination <= on_wire.ip_destination;
                    protocol <= on_wire.protocol;
                    rx_queue <= on_wire.rx_queue;
                    entry_valid <= on_wire.entry_valid;
                    table_value <= on_wire.table_value;
                    table_key <= on_wire.table_key;
                    dest_mac <= on_wire.dest_mac;
                    socket_bound <= on_wire.socket_bound;
                    pkt_valid <= 1'b1;
                    if (idle_enabled && $urandom_range(0, 5) == 0)
                        send_gap = $urandom_range(1, 4);
                end
                else
                    pkt_valid <= 1'b0;
            end
        end
    end

    // Result channel monitor: checks each transfer against the oldest expected decision.
    always @(posedge clk or negedge rst_n)
    begin
        decision_t want;
        if (!rst_n)
        begin
            res_stall <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (res_valid && !res_stall)
            begin
                if (decisions_due.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("%0t: result with nothing expected: action=%0d", $time, action);
                end
                else
                begin
                    want = decisions_due.pop_front();
                    action_tally[want.action]++;
                    if (action !== want.action || out_port !== want.out_port
                        || socket_queue !== want.socket_queue
                        || mac_rewritten !== want.mac_rewritten || new_mac !== want.new_mac)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                        begin
                            $display("%0t: mismatch: expected action=%0d port=%0d queue=%0d rewrite=%0b mac=%h",
                                     $time, want.action, want.out_port, want.socket_queue,
                                     want.mac_rewritten, want.new_mac);
                            $display("    got action=%0d port=%0d queue=%0d rewrite=%0b mac=%h",
                                     action, out_port, socket_queue, mac_rewritten, new_mac);
                        end
                    end
                end
            end
            // Stall bursts at random.
            if (stall_left > 0)
            begin
                stall_left--;
                res_stall <= 1'b1;
            end
            else if (idle_enabled && $urandom_range(0, 6) == 0)
            begin
                stall_left = $urandom_range(0, 3);
                res_stall <= 1'b1;
            end
            else
                res_stall <= 1'b0;
        end
    end

    // Watchdog on cycles without any transfer; covers the table clearing after reset.
    always @(posedge clk)
    begin
        if (!rst_n || (pkt_valid && !pkt_stall) || (res_valid && !res_stall)
            || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    // Stimulus sequence.
    initial
    begin
        logic [31:0] w;
        for (int i = 0; i < pfc_pkg::ROUTE_ENTRIES; i++)
        begin
            route_ok[i] = 1'b0;
            route_key[i] = '0;
            route_ifc[i] = '0;
            route_mac[i] = '0;
        end
        for (int i = 0; i < pfc_pkg::PORT_ENTRIES; i++)
        begin
            port_ok[i] = 1'b0;
            port_val[i] = '0;
        end
        for (int i = 0; i < pfc_pkg::QUEUE_ENTRIES; i++)
            queue_cfg[i] = 2'b00;
        for (int i = 0; i < 8; i++)
            action_tally[i] = 0;
        steer_protocol = pfc_pkg::PROTO_ICMP;

        for (int i = 0; i < 16; i++)
        begin
            w = $urandom();
            slot_pool[i] = w[8:0];
            if (i < 8)
            begin
                addr_pool[i] = $urandom();
                queue_pool[i] = {2'b00, w[14:9]};
            end
        end
        slot_pool[0] = 9'd0;
        slot_pool[1] = 9'd511;
        addr_pool[0] = 32'h0;
        addr_pool[1] = 32'hFFFFFFFF;
        queue_pool[0] = 8'd0;
        queue_pool[1] = 8'd63;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Out-of-range receive queue and frames shorter than an Ethernet header pass.
        add_packet(pfc_pkg::ETHTYPE_IPV4, 16'hFFFF, 32'h0, pfc_pkg::PROTO_ICMP, 8'd64);
        add_packet(pfc_pkg::ETHTYPE_IPV4, 16'd0, 32'h0, pfc_pkg::PROTO_ICMP, 8'd255);
        // Queue 5 has a socket, queue 6 is enabled without one, queue 64 is out of range.
        add_queue(8'd5, 1'b1, 32'd1, 1'b1);
        add_queue(8'd6, 1'b1, 32'hFFFFFFFF, 1'b0);
        add_queue(8'd64, 1'b1, 32'd1, 1'b1);
        // Header length limits for IPv4 and IPv6, then the missing socket and other types.
        add_packet(pfc_pkg::ETHTYPE_IPV4, 16'd13, 32'h0, pfc_pkg::PROTO_ICMP, 8'd5);
        add_packet(pfc_pkg::ETHTYPE_IPV4, 16'd33, 32'h0, pfc_pkg::PROTO_ICMP, 8'd5);
        add_packet(pfc_pkg::ETHTYPE_IPV4, 16'd34, 32'h0, pfc_pkg::PROTO_ICMP, 8'd5);
        add_packet(pfc_pkg::ETHTYPE_IPV6, 16'd53, 32'h0, pfc_pkg::PROTO_ICMP, 8'd5);
        add_packet(pfc_pkg::ETHTYPE_IPV6, 16'd54, 32'h0, pfc_pkg::PROTO_ICMP, 8'd5);
        add_packet(pfc_pkg::ETHTYPE_IPV4, 16'd34, 32'h0, pfc_pkg::PROTO_ICMP, 8'd6);
        add_packet(16'hFFFF, 16'hFFFF, 32'hFFFFFFFF, pfc_pkg::PROTO_ICMP, 8'd5);
        // Build a route chain step by step: invalid interface, missing port, full redirect.
        add_route(32'hC0A80001, 1'b1, 32'd10, 48'hFFFF_FFFF_FFFF);
        add_packet(pfc_pkg::ETHTYPE_IPV4, 16'd64, 32'hC0A80001, pfc_pkg::PROTO_ICMP, 8'd5);
        add_port(9'd10, 1'b1, 32'd20);
        add_packet(pfc_pkg::ETHTYPE_IPV4, 16'd64, 32'hC0A80001, pfc_pkg::PROTO_ICMP, 8'd5);
        add_port(9'd20, 1'b1, 32'd0);
        add_packet(pfc_pkg::ETHTYPE_IPV4, 16'd64, 32'hC0A80001, pfc_pkg::PROTO_ICMP, 8'd5);
        // A port value past the port table drops.
        add_port(9'd511, 1'b1, 32'hFFFFFFFF);
        add_route(32'hFFFFFFFF, 1'b1, 32'd511, 48'h0);
        add_packet(pfc_pkg::ETHTYPE_IPV4, 16'd34, 32'hFFFFFFFF, 8'd0, 8'd63);
        // Removals, including a key that is not present.
        add_route(32'hC0A80001, 1'b0, 32'd0, 48'h0);
        add_route(32'h0, 1'b0, 32'd0, 48'h0);
        add_port(9'd10, 1'b0, 32'd0);
        add_queue(8'd5, 1'b0, 32'd1, 1'b1);

        write_steer_protocol(8'd0);
        repeat (RANDOM_BATCH) add_random_request();

        write_steer_protocol(8'd255);
        repeat (RANDOM_BATCH) add_random_request();

        // Fill the route table past its size, hit the new routes, then remove them.
        w = $urandom();
        write_steer_protocol(w[7:0]);
        for (int i = 0; i < pfc_pkg::ROUTE_ENTRIES + 6; i++)
        begin
            flood_keys[i] = $urandom();
            add_route(flood_keys[i], 1'b1, pick_ifc(), rand_mac());
        end
        repeat (30)
        begin
            w = $urandom();
            add_packet(pfc_pkg::ETHTYPE_IPV4, 16'd60,
                       flood_keys[$urandom_range(0, pfc_pkg::ROUTE_ENTRIES + 5)],
                       w[0] ? steer_protocol : w[15:8], pick_queue());
        end
        for (int i = 0; i < pfc_pkg::ROUTE_ENTRIES + 6; i++)
            add_route(flood_keys[i], 1'b0, 32'd0, 48'h0);
        repeat (RANDOM_BATCH) add_random_request();

        // Last part at full rate on both sides.
        write_steer_protocol(pfc_pkg::PROTO_ICMP);
        idle_enabled = 1'b0;
        repeat (RANDOM_BATCH) add_random_request();

        wait_idle();
        repeat (PIPE_LATENCY + 8) @(posedge clk);
        mismatch_count += decisions_due.size();

        $display("Checked %0d requests under %0d protocol settings: %0d redirects, %0d socket,",
                 requests_accepted, protocol_settings, action_tally[pfc_pkg::ACT_PORT],
                 action_tally[pfc_pkg::ACT_SOCKET]);
        $display("%0d drops, %0d passes, %0d write acks, %0d table-full answers.",
                 action_tally[pfc_pkg::ACT_DROP], action_tally[pfc_pkg::ACT_PASS],
                 action_tally[pfc_pkg::ACT_WRITE_OK], action_tally[pfc_pkg::ACT_FULL]);
        if (mismatch_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
